// ===== design/ntsc_pkg.sv =====
`timescale 1ns / 1ps
package ntsc_pkg;

    localparam int CNT_W    = 11;
    localparam int LETTER_W = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    // characters of the tree grammar
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    // configuration register indexes
    localparam logic CFG_ROOT_LETTER  = 1'b0;
    localparam logic CFG_QUERY_LETTER = 1'b1;

    localparam logic [LETTER_W-1:0] ROOT_LETTER_RST  = 7'd65;
    localparam logic [LETTER_W-1:0] QUERY_LETTER_RST = 7'd67;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_CHAR   = 3'd1,
        ST_WRONG_ROOT = 3'd2,
        ST_STRUCTURE  = 3'd3,
        ST_UNBALANCED = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_OVERFLOW   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_NODE = 2'd0,
        MODE_HELD = 2'd1,
        MODE_SEP  = 2'd2
    } t_mode;

    // summary of one finished run
    typedef struct packed {
        t_status             status;
        logic [CNT_W-1:0]    node_total;
        logic [CNT_W-1:0]    leaf_total;
        logic [CNT_W-1:0]    inner_total;
        logic [CNT_W-1:0]    tree_height;
        logic [CNT_W-1:0]    tree_degree;
        logic                query_found;
        logic [LETTER_W-1:0] query_parent;
    } t_run_sum;

    // one stack entry: parent letter and its child count
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [CNT_W-1:0]    cnt;
    } t_stack_ent;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ===== design/ntsc_front.sv =====
`timescale 1ns / 1ps
module ntsc_front #(
    parameter int STACK_DEPTH = 1024,
    parameter int CHILD_SLOTS = 32,
    localparam int SP_W   = $clog2(STACK_DEPTH + 1),
    localparam int SLOT_W = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1,
    localparam int CCNT_W = $clog2(CHILD_SLOTS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_char,
    input  logic                      i_eos,
    input  logic [6:0]                i_root,
    input  logic [6:0]                i_query,
    output logic                      o_push,
    output ntsc_pkg::t_run_sum        o_sum,
    output logic [CCNT_W-1:0]         o_cnt,
    output logic                      o_cw_en,
    output logic [SLOT_W-1:0]         o_cw_slot,
    output logic [6:0]                o_cw_letter
);
    import ntsc_pkg::*;

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW    = (SP_W > CNT_W) ? SP_W : CNT_W;

    t_mode                 r_mode, n_mode;
    t_status               r_err, n_err;
    logic [LETTER_W-1:0]   r_held, n_held;
    logic [SP_W-1:0]       r_sp, n_sp;
    logic [LETTER_W-1:0]   r_top_letter, n_top_letter;
    logic [CNT_W-1:0]      r_top_cnt, n_top_cnt;
    t_stack_ent            r_below;
    logic [CNT_W-1:0]      r_node, n_node;
    logic [CNT_W-1:0]      r_leaf, n_leaf;
    logic [CNT_W-1:0]      r_inner, n_inner;
    logic [CNT_W-1:0]      r_maxd, n_maxd;
    logic [CNT_W-1:0]      r_maxc, n_maxc;
    logic                  r_qseen, n_qseen;
    logic [LETTER_W-1:0]   r_qparent, n_qparent;
    logic [CCNT_W-1:0]     r_qcnt, n_qcnt;

    // entries below the top of stack; the top lives in registers
    t_stack_ent            stack_mem [STACK_DEPTH];
    logic                  st_we;
    logic [IDX_W-1:0]      st_wa;
    logic [IDX_W-1:0]      st_ra;
    t_stack_ent            st_wd;

    logic                  sep_go;
    logic [LETTER_W-1:0]   parent;
    logic [DW-1:0]         sp_ext;
    logic [CNT_W-1:0]      depth;

    assign sp_ext = DW'(r_sp);
    assign depth  = (sp_ext >= DW'(CNT_MAX)) ? CNT_MAX : CNT_W'(sp_ext + 1'b1);
    assign parent = (r_sp != '0) ? r_top_letter : '0;

    // parse step for one transfer, then end of run handling
    always_comb begin
        n_mode       = r_mode;
        n_err        = r_err;
        n_held       = r_held;
        n_sp         = r_sp;
        n_top_letter = r_top_letter;
        n_top_cnt    = r_top_cnt;
        n_node       = r_node;
        n_leaf       = r_leaf;
        n_inner      = r_inner;
        n_maxd       = r_maxd;
        n_maxc       = r_maxc;
        n_qseen      = r_qseen;
        n_qparent    = r_qparent;
        n_qcnt       = r_qcnt;
        st_we        = 1'b0;
        st_wa        = IDX_W'(r_sp - 1'b1);
        st_wd        = '{letter: r_top_letter, cnt: r_top_cnt};
        o_cw_en      = 1'b0;
        o_cw_slot    = r_qcnt[SLOT_W-1:0];
        o_cw_letter  = i_char[6:0];
        o_push       = 1'b0;
        o_sum        = '0;
        o_cnt        = '0;
        sep_go       = 1'b0;

        if (i_valid) begin
            if (r_err == ST_OK) begin
                case (r_mode)
                    MODE_NODE: begin
                        if (!(i_char inside {[CH_A:CH_Z]})) begin
                            n_err = ST_BAD_CHAR;
                        end else begin
                            n_node = sat_inc(r_node);
                            if (r_node == '0 && i_char != {1'b0, i_root}) begin
                                n_err = ST_WRONG_ROOT;
                            end else begin
                                if (depth > r_maxd) begin
                                    n_maxd = depth;
                                end
                                if (r_sp != '0) begin
                                    n_top_cnt = sat_inc(r_top_cnt);
                                end
                                if (i_char[6:0] == i_query) begin
                                    n_qseen   = 1'b1;
                                    n_qparent = parent;
                                end
                                if (r_sp != '0 && parent == i_query &&
                                    r_qcnt < CCNT_W'(CHILD_SLOTS)) begin
                                    o_cw_en = 1'b1;
                                    n_qcnt  = r_qcnt + 1'b1;
                                end
                                n_held = i_char[6:0];
                                n_mode = MODE_HELD;
                            end
                        end
                    end
                    MODE_HELD: begin
                        if (i_char == CH_OPEN) begin
                            n_inner = sat_inc(r_inner);
                            if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                st_we        = (r_sp != '0);
                                n_top_letter = r_held;
                                n_top_cnt    = '0;
                                n_sp         = r_sp + 1'b1;
                                n_mode       = MODE_NODE;
                            end
                        end else begin
                            n_leaf = sat_inc(r_leaf);
                            n_mode = MODE_SEP;
                            sep_go = 1'b1;
                        end
                    end
                    MODE_SEP: begin
                        sep_go = 1'b1;
                    end
                    default: begin
                        n_mode = MODE_NODE;
                    end
                endcase

                // comma or closing parenthesis after a node
                if (sep_go) begin
                    if (i_char == CH_COMMA) begin
                        if (r_sp == '0) begin
                            n_err = ST_STRUCTURE;
                        end else begin
                            n_mode = MODE_NODE;
                        end
                    end else if (i_char == CH_CLOSE) begin
                        if (r_sp == '0) begin
                            n_err = ST_UNBALANCED;
                        end else begin
                            if (r_top_cnt > r_maxc) begin
                                n_maxc = r_top_cnt;
                            end
                            n_top_letter = r_below.letter;
                            n_top_cnt    = r_below.cnt;
                            n_sp         = r_sp - 1'b1;
                            n_mode       = MODE_SEP;
                        end
                    end else begin
                        n_err = ST_BAD_CHAR;
                    end
                end
            end

            // close the run and hand its summary to the queue
            if (i_eos) begin
                if (n_err == ST_OK) begin
                    if (n_mode == MODE_HELD) begin
                        n_leaf = sat_inc(n_leaf);
                    end
                    if (n_sp != '0) begin
                        n_err = ST_UNBALANCED;
                    end else if (n_node == '0) begin
                        n_err = ST_EMPTY;
                    end
                end
                o_push = 1'b1;
                o_sum.status = n_err;
                if (n_err == ST_OK) begin
                    o_sum.node_total   = n_node;
                    o_sum.leaf_total   = n_leaf;
                    o_sum.inner_total  = n_inner;
                    o_sum.tree_height  = n_maxd;
                    o_sum.tree_degree  = n_maxc;
                    o_sum.query_found  = n_qseen;
                    o_sum.query_parent = n_qparent;
                    o_cnt              = n_qcnt;
                end
                n_mode    = MODE_NODE;
                n_err     = ST_OK;
                n_held    = '0;
                n_sp      = '0;
                n_node    = '0;
                n_leaf    = '0;
                n_inner   = '0;
                n_maxd    = '0;
                n_maxc    = '0;
                n_qseen   = 1'b0;
                n_qparent = '0;
                n_qcnt    = '0;
            end
        end
    end

    assign st_ra = IDX_W'(n_sp - 2'd2);

    // stack memory with write-to-read bypass for the entry below the top
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            stack_mem[st_wa] <= st_wd;
        end
        if (st_we && st_wa == st_ra) begin
            r_below <= st_wd;
        end else begin
            r_below <= stack_mem[st_ra];
        end
    end

    // top of stack payload
    always_ff @(posedge i_clk) begin
        r_top_letter <= n_top_letter;
        r_top_cnt    <= n_top_cnt;
    end

    // parser state and run counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_NODE;
            r_err     <= ST_OK;
            r_held    <= '0;
            r_sp      <= '0;
            r_node    <= '0;
            r_leaf    <= '0;
            r_inner   <= '0;
            r_maxd    <= '0;
            r_maxc    <= '0;
            r_qseen   <= 1'b0;
            r_qparent <= '0;
            r_qcnt    <= '0;
        end else begin
            r_mode    <= n_mode;
            r_err     <= n_err;
            r_held    <= n_held;
            r_sp      <= n_sp;
            r_node    <= n_node;
            r_leaf    <= n_leaf;
            r_inner   <= n_inner;
            r_maxd    <= n_maxd;
            r_maxc    <= n_maxc;
            r_qseen   <= n_qseen;
            r_qparent <= n_qparent;
            r_qcnt    <= n_qcnt;
        end
    end

endmodule

// ===== design/ntsc_run_queue.sv =====
`timescale 1ns / 1ps
module ntsc_run_queue #(
    parameter int CHILD_SLOTS = 32,
    localparam int SLOT_W = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1,
    localparam int CCNT_W = $clog2(CHILD_SLOTS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  ntsc_pkg::t_run_sum        i_sum,
    input  logic [CCNT_W-1:0]         i_cnt,
    input  logic                      i_cw_en,
    input  logic [SLOT_W-1:0]         i_cw_slot,
    input  logic [6:0]                i_cw_letter,
    input  logic                      i_pop,
    input  logic                      i_rd_en,
    input  logic [SLOT_W-1:0]         i_rd_slot,
    output logic                      o_full,
    output logic                      o_valid,
    output ntsc_pkg::t_run_sum        o_sum,
    output logic [CCNT_W-1:0]         o_cnt,
    output logic [6:0]                o_rd_data
);
    import ntsc_pkg::*;

    localparam int AW = $clog2(2 * CHILD_SLOTS);

    // two run slots, each owning one bank of the child letter memory
    t_run_sum            r_sum [2];
    logic [CCNT_W-1:0]   r_cnt [2];
    logic                r_wr, r_rd;
    logic [1:0]          r_level;
    logic [LETTER_W-1:0] child_mem [2 * CHILD_SLOTS];
    logic [LETTER_W-1:0] r_rd_data;
    logic [AW-1:0]       wa, ra;

    assign o_full    = (r_level == 2'd2);
    assign o_valid   = (r_level != 2'd0);
    assign o_sum     = r_sum[r_rd];
    assign o_cnt     = r_cnt[r_rd];
    assign o_rd_data = r_rd_data;

    assign wa = AW'(i_cw_slot) + (r_wr ? AW'(CHILD_SLOTS) : AW'(0));
    assign ra = AW'(i_rd_slot) + (r_rd ? AW'(CHILD_SLOTS) : AW'(0));

    // summary slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_sum[r_wr] <= i_sum;
            r_cnt[r_wr] <= i_cnt;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    // child letter memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cw_en) begin
            child_mem[wa] <= i_cw_letter;
        end
        if (i_rd_en) begin
            r_rd_data <= child_mem[ra];
        end
    end

endmodule

// ===== design/ntsc_back.sv =====
`timescale 1ns / 1ps
module ntsc_back #(
    parameter int CHILD_SLOTS = 32,
    localparam int SLOT_W = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1,
    localparam int CCNT_W = $clog2(CHILD_SLOTS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  ntsc_pkg::t_run_sum        i_sum,
    input  logic [CCNT_W-1:0]         i_cnt,
    input  logic [6:0]                i_rd_data,
    input  logic                      i_pop,
    output logic                      o_take,
    output logic                      o_rd_en,
    output logic [SLOT_W-1:0]         o_rd_slot,
    output logic                      o_empty,
    output logic [2:0]                o_status,
    output logic [10:0]               o_node_total,
    output logic [10:0]               o_leaf_total,
    output logic [10:0]               o_inner_total,
    output logic [10:0]               o_tree_height,
    output logic [10:0]               o_tree_degree,
    output logic                      o_query_found,
    output logic [6:0]                o_query_parent,
    output logic [6:0]                o_child_letter,
    output logic                      o_last_result
);
    import ntsc_pkg::*;

    logic [SLOT_W-1:0] r_k, n_k;
    logic              r_oval, n_oval;
    t_run_sum          r_osum;
    logic              r_olast;
    logic              r_ozero;
    logic              load;
    logic              last;
    logic [SLOT_W-1:0] k_last;

    // one result per recorded child, or one when none
    assign k_last = (i_cnt == '0) ? '0 : SLOT_W'(i_cnt - 1'b1);
    assign last   = (r_k == k_last);
    assign load   = i_valid && (!r_oval || i_pop);

    assign o_take    = load && last;
    assign o_rd_en   = load;
    assign o_rd_slot = r_k;

    always_comb begin
        n_k    = r_k;
        n_oval = r_oval;
        if (load) begin
            n_k    = last ? '0 : r_k + 1'b1;
            n_oval = 1'b1;
        end else if (i_pop) begin
            n_oval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_oval <= 1'b0;
        end else begin
            r_k    <= n_k;
            r_oval <= n_oval;
        end
    end

    // output register; the child letter comes from the memory read register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_osum  <= i_sum;
            r_olast <= last;
            r_ozero <= (i_cnt == '0);
        end
    end

    assign o_empty        = !r_oval;
    assign o_status       = r_osum.status;
    assign o_node_total   = r_osum.node_total;
    assign o_leaf_total   = r_osum.leaf_total;
    assign o_inner_total  = r_osum.inner_total;
    assign o_tree_height  = r_osum.tree_height;
    assign o_tree_degree  = r_osum.tree_degree;
    assign o_query_found  = r_osum.query_found;
    assign o_query_parent = r_osum.query_parent;
    assign o_child_letter = r_ozero ? '0 : i_rd_data;
    assign o_last_result  = r_olast;

endmodule

// ===== design/nested_tree_string_checker.sv =====
`timescale 1ns / 1ps
// Tree string checker: one character is taken per clock while full is low; the parser
// touches only the top of stack (held in registers, with the entries below in a
// STACK_DEPTH-entry memory) and its counters. On the end_of_string transfer the run summary
// moves into a two-run queue, and the result side then delivers max(children recorded, 1)
// results at one per cycle while pop takes each one; the first one passes through the
// queue slot and the output register. full rises only while two finished runs still wait
// to be delivered, since each queued run owns one bank of the child letter memory.
module nested_tree_string_checker #(
    parameter int STACK_DEPTH = 1024,
    parameter int CHILD_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_string,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [10:0] o_node_total,
    output logic [10:0] o_leaf_total,
    output logic [10:0] o_inner_total,
    output logic [10:0] o_tree_height,
    output logic [10:0] o_tree_degree,
    output logic        o_query_found,
    output logic [6:0]  o_query_parent,
    output logic [6:0]  o_child_letter,
    output logic        o_last_result,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import ntsc_pkg::*;

    localparam int SLOT_W = (CHILD_SLOTS > 1) ? $clog2(CHILD_SLOTS) : 1;
    localparam int CCNT_W = $clog2(CHILD_SLOTS + 1);

    logic [LETTER_W-1:0] r_root_letter;
    logic [LETTER_W-1:0] r_query_letter;

    logic                accept;
    logic                q_full;
    logic                fr_push;
    t_run_sum            fr_sum;
    logic [CCNT_W-1:0]   fr_cnt;
    logic                cw_en;
    logic [SLOT_W-1:0]   cw_slot;
    logic [6:0]          cw_letter;
    logic                q_valid;
    t_run_sum            q_sum;
    logic [CCNT_W-1:0]   q_cnt;
    logic [6:0]          q_rd_data;
    logic                bk_take;
    logic                bk_rd_en;
    logic [SLOT_W-1:0]   bk_rd_slot;

    assign accept = push && !q_full;
    assign full   = q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_letter  <= ROOT_LETTER_RST;
            r_query_letter <= QUERY_LETTER_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ROOT_LETTER:  r_root_letter  <= i_cfg_data;
                CFG_QUERY_LETTER: r_query_letter <= i_cfg_data;
                default:          r_root_letter  <= r_root_letter;
            endcase
        end
    end

    ntsc_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .CHILD_SLOTS (CHILD_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_char      (i_char_code),
        .i_eos       (i_end_of_string),
        .i_root      (r_root_letter),
        .i_query     (r_query_letter),
        .o_push      (fr_push),
        .o_sum       (fr_sum),
        .o_cnt       (fr_cnt),
        .o_cw_en     (cw_en),
        .o_cw_slot   (cw_slot),
        .o_cw_letter (cw_letter)
    );

    ntsc_run_queue #(
        .CHILD_SLOTS (CHILD_SLOTS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fr_push),
        .i_sum       (fr_sum),
        .i_cnt       (fr_cnt),
        .i_cw_en     (cw_en),
        .i_cw_slot   (cw_slot),
        .i_cw_letter (cw_letter),
        .i_pop       (bk_take),
        .i_rd_en     (bk_rd_en),
        .i_rd_slot   (bk_rd_slot),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_sum       (q_sum),
        .o_cnt       (q_cnt),
        .o_rd_data   (q_rd_data)
    );

    ntsc_back #(
        .CHILD_SLOTS (CHILD_SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_sum          (q_sum),
        .i_cnt          (q_cnt),
        .i_rd_data      (q_rd_data),
        .i_pop          (pop),
        .o_take         (bk_take),
        .o_rd_en        (bk_rd_en),
        .o_rd_slot      (bk_rd_slot),
        .o_empty        (empty),
        .o_status       (o_status),
        .o_node_total   (o_node_total),
        .o_leaf_total   (o_leaf_total),
        .o_inner_total  (o_inner_total),
        .o_tree_height  (o_tree_height),
        .o_tree_degree  (o_tree_degree),
        .o_query_found  (o_query_found),
        .o_query_parent (o_query_parent),
        .o_child_letter (o_child_letter),
        .o_last_result  (o_last_result)
    );

    // a run summary never lands in a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_full |-> !fr_push)
        else $error("run summary pushed into full queue");

    // an error result is the only and last one of its run, with zero counts
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |->
            (o_last_result && o_node_total == '0 && o_child_letter == '0))
        else $error("error result carries run data");

    // a reported child implies a clean run in which the query letter appeared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_child_letter != '0) |-> (o_query_found && o_status == ST_OK))
        else $error("child reported without query node");

    // the queue is only drained while it holds a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n) bk_take |-> q_valid)
        else $error("run taken from empty queue");

endmodule
